// File: hw/rtl/fbtp_pkg.sv
// Shared constants, types and the character decoder of the five-bit text packer.
`default_nettype none

package fbtp_pkg;

	localparam int BYTE_W = 8;
	localparam int CODE_W = 5;

	// Five-bit codes
	localparam logic [CODE_W-1:0] CODE_AT     = 5'd26;
	localparam logic [CODE_W-1:0] CODE_HASH   = 5'd27;
	localparam logic [CODE_W-1:0] CODE_COMMA  = 5'd28;
	localparam logic [CODE_W-1:0] CODE_PERIOD = 5'd29;
	localparam logic [CODE_W-1:0] CODE_SPACE  = 5'd30;
	localparam logic [CODE_W-1:0] CODE_ESCAPE = 5'd31;

	// ASCII characters of interest
	localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'h0A;
	localparam logic [BYTE_W-1:0] CHAR_SPACE   = 8'h20;
	localparam logic [BYTE_W-1:0] CHAR_HASH    = 8'h23;
	localparam logic [BYTE_W-1:0] CHAR_COMMA   = 8'h2C;
	localparam logic [BYTE_W-1:0] CHAR_PERIOD  = 8'h2E;
	localparam logic [BYTE_W-1:0] CHAR_ZERO    = 8'h30;
	localparam logic [BYTE_W-1:0] CHAR_NINE    = 8'h39;
	localparam logic [BYTE_W-1:0] CHAR_AT      = 8'h40;
	localparam logic [BYTE_W-1:0] CHAR_A       = 8'h61;
	localparam logic [BYTE_W-1:0] CHAR_Z       = 8'h7A;

	typedef struct packed {
		logic              hit;
		logic [CODE_W-1:0] code;
	} char_code_t;

	// Map a character to its code; hit is low for characters without one
	function automatic char_code_t code_lookup(input logic [BYTE_W-1:0] ch);
		char_code_t r;
		logic [BYTE_W-1:0] ofs;
		ofs = ch - CHAR_A;
		r.hit = 1'b1;
		r.code = CODE_AT;
		unique case (ch) inside
			[CHAR_A:CHAR_Z]: r.code = ofs[CODE_W-1:0];
			CHAR_AT, CHAR_NEWLINE: r.code = CODE_AT;
			CHAR_HASH: r.code = CODE_HASH;
			CHAR_COMMA: r.code = CODE_COMMA;
			CHAR_PERIOD: r.code = CODE_PERIOD;
			CHAR_SPACE: r.code = CODE_SPACE;
			default: r.hit = 1'b0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/five_bit_text_packer_top.sv
// Five-bit text packer: packs ASCII text into 5-bit codes, MSB first, byte by byte.
//
// Input channel (text_valid/text_stall): one character per transaction with
// end_of_text marking the last one. Output channel (packed_valid/packed_stall):
// one packed byte per transaction, final_byte on the last byte of a text.
// A character is taken every cycle while the segment queue has room. The front
// end turns each character into 0 to 15+NUMBER_WIDTH code bits; the packer
// emits at most one byte per cycle, so characters that yield more than one
// byte (number flushes, end of text) hold up the queue while they drain, and
// text_stall rises only when the queue is full.
// The first byte of a transaction passes the queue write, the accumulator
// merge and the output register before it appears.
// While packed_stall is high the output register holds its byte; the front
// end keeps accepting characters until the QUEUE_DEPTH entries are filled.
// Reset clears the digit run, the queue, the bit accumulator and the output
// valid; the next character starts a new text. Each end_of_text also clears
// the digit run and, after the padded final byte, the bit accumulator.
`default_nettype none

module five_bit_text_packer_top #(
	parameter int NUMBER_WIDTH = 10,
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       text_valid,
	output logic            text_stall,
	input  wire logic [7:0] text_byte,
	input  wire logic       end_of_text,
	output logic            packed_valid,
	input  wire logic       packed_stall,
	output logic [7:0]      packed_byte,
	output logic            final_byte
);

	localparam int SEG_W = 3 * fbtp_pkg::CODE_W + NUMBER_WIDTH;
	localparam int LEN_W = $clog2(SEG_W + 1);

	logic             q_full;
	logic             q_not_empty;
	logic             push;
	logic [SEG_W-1:0] push_seg;
	logic [LEN_W-1:0] push_len;
	logic             push_last;
	logic             pop;
	logic [SEG_W-1:0] pop_seg;
	logic [LEN_W-1:0] pop_len;
	logic             pop_last;

	assign text_stall = q_full;

	fbtp_front #(
		.NUMBER_WIDTH(NUMBER_WIDTH),
		.SEG_W(SEG_W),
		.LEN_W(LEN_W)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.text_valid(text_valid),
		.text_byte(text_byte),
		.end_of_text(end_of_text),
		.accept(!q_full),
		.push(push),
		.push_seg(push_seg),
		.push_len(push_len),
		.push_last(push_last)
	);

	fbtp_queue #(
		.SEG_W(SEG_W),
		.LEN_W(LEN_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_seg(push_seg),
		.push_len(push_len),
		.push_last(push_last),
		.full(q_full),
		.not_empty(q_not_empty),
		.pop(pop),
		.pop_seg(pop_seg),
		.pop_len(pop_len),
		.pop_last(pop_last)
	);

	fbtp_back #(
		.SEG_W(SEG_W),
		.LEN_W(LEN_W)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_not_empty),
		.q_seg(pop_seg),
		.q_len(pop_len),
		.q_last(pop_last),
		.pop(pop),
		.packed_valid(packed_valid),
		.packed_stall(packed_stall),
		.packed_byte(packed_byte),
		.final_byte(final_byte)
	);

endmodule

`default_nettype wire

// File: hw/rtl/fbtp_front.sv
// Front end: classifies characters, tracks digit runs and builds bit segments.
`default_nettype none

module fbtp_front #(
	parameter int NUMBER_WIDTH = 10,
	parameter int SEG_W = 25,
	parameter int LEN_W = 5
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             text_valid,
	input  wire logic [7:0]       text_byte,
	input  wire logic             end_of_text,
	input  wire logic             accept,
	output logic                  push,
	output logic [SEG_W-1:0]      push_seg,
	output logic [LEN_W-1:0]      push_len,
	output logic                  push_last
);

	localparam int CW = fbtp_pkg::CODE_W;
	localparam logic [LEN_W-1:0] LEN_CODE = LEN_W'(CW);
	localparam logic [LEN_W-1:0] LEN_FLUSH = LEN_W'(CW + NUMBER_WIDTH);

	logic [NUMBER_WIDTH-1:0] num_q;
	logic                    in_num_q;

	fbtp_pkg::char_code_t    cc;
	logic                    is_digit;
	logic [NUMBER_WIDTH-1:0] num_next;
	logic [NUMBER_WIDTH-1:0] flush_val;
	logic                    has_f;
	logic                    has_c;
	logic                    has_a;
	logic [LEN_W-1:0]        off_c;
	logic [LEN_W-1:0]        off_a;
	logic [SEG_W-1:0]        seg_f;
	logic [SEG_W-1:0]        seg_c;
	logic [SEG_W-1:0]        seg_a;

	// Classify the character and extend the digit run
	always_comb begin
		cc = fbtp_pkg::code_lookup(text_byte);
		is_digit = (text_byte >= fbtp_pkg::CHAR_ZERO) && (text_byte <= fbtp_pkg::CHAR_NINE);
		num_next = NUMBER_WIDTH'(num_q << 3) + NUMBER_WIDTH'(num_q << 1)
			+ NUMBER_WIDTH'(text_byte[3:0]);
	end

	// Build the segment: optional number flush, optional code, optional closing '@'
	always_comb begin
		flush_val = is_digit ? num_next : num_q;
		has_f = is_digit ? end_of_text : in_num_q;
		has_c = !is_digit && cc.hit;
		has_a = end_of_text && (text_byte != fbtp_pkg::CHAR_NEWLINE);
		off_c = has_f ? LEN_FLUSH : '0;
		off_a = off_c + (has_c ? LEN_CODE : '0);
		seg_f = has_f ? {fbtp_pkg::CODE_ESCAPE, flush_val, {(SEG_W-CW-NUMBER_WIDTH){1'b0}}}
			: '0;
		seg_c = has_c ? ({cc.code, {(SEG_W-CW){1'b0}}} >> off_c) : '0;
		seg_a = has_a ? ({fbtp_pkg::CODE_AT, {(SEG_W-CW){1'b0}}} >> off_a) : '0;
		push_seg = seg_f | seg_c | seg_a;
		push_len = off_a + (has_a ? LEN_CODE : '0);
		push_last = end_of_text;
		push = text_valid && accept && (has_f || has_c || has_a);
	end

	// Hold the digit run between transactions; drop it on a non-digit or at the end of text
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q <= '0;
			in_num_q <= 1'b0;
		end else if (text_valid && accept) begin
			in_num_q <= is_digit && !end_of_text;
			num_q <= (is_digit && !end_of_text) ? num_next : '0;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/fbtp_queue.sv
// Short queue of bit segments between front end and packer.
`default_nettype none

module fbtp_queue #(
	parameter int SEG_W = 25,
	parameter int LEN_W = 5,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [SEG_W-1:0] push_seg,
	input  wire logic [LEN_W-1:0] push_len,
	input  wire logic             push_last,
	output logic                  full,
	output logic                  not_empty,
	input  wire logic             pop,
	output logic [SEG_W-1:0]      pop_seg,
	output logic [LEN_W-1:0]      pop_len,
	output logic                  pop_last
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	logic [SEG_W-1:0] seg_q  [DEPTH];
	logic [LEN_W-1:0] len_q  [DEPTH];
	logic             last_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	always_comb begin
		full = (count_q == CNT_FULL);
		not_empty = (count_q != '0);
		pop_seg = seg_q[rd_ptr_q];
		pop_len = len_q[rd_ptr_q];
		pop_last = last_q[rd_ptr_q];
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			seg_q[wr_ptr_q] <= push_seg;
			len_q[wr_ptr_q] <= push_len;
			last_q[wr_ptr_q] <= push_last;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/fbtp_back.sv
// Back end: merges segments into a bit accumulator and emits packed bytes.
`default_nettype none

module fbtp_back #(
	parameter int SEG_W = 25,
	parameter int LEN_W = 5
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             q_valid,
	input  wire logic [SEG_W-1:0] q_seg,
	input  wire logic [LEN_W-1:0] q_len,
	input  wire logic             q_last,
	output logic                  pop,
	output logic                  packed_valid,
	input  wire logic             packed_stall,
	output logic [7:0]            packed_byte,
	output logic                  final_byte
);

	localparam int BW = fbtp_pkg::BYTE_W;
	localparam int ACC_W = SEG_W + BW - 1;
	localparam int CNT_W = $clog2(ACC_W + 1);
	localparam logic [CNT_W-1:0] CNT_BYTE = CNT_W'(BW);

	logic [ACC_W-1:0] acc_q;
	logic [CNT_W-1:0] cnt_q;
	logic             last_q;
	logic             out_valid_q;
	logic [BW-1:0]    byte_q;
	logic             final_q;

	logic             out_free;
	logic             emit;
	logic [BW-1:0]    emit_byte;
	logic             emit_final;
	logic [ACC_W-1:0] acc_a;
	logic [CNT_W-1:0] cnt_a;
	logic             last_a;
	logic [ACC_W-1:0] acc_n;
	logic [CNT_W-1:0] cnt_n;
	logic             last_n;

	// Emit the top byte, then merge the next segment below the remaining bits
	always_comb begin
		out_free = !out_valid_q || !packed_stall;
		emit = out_free && ((cnt_q >= CNT_BYTE) || (last_q && (cnt_q != '0)));
		emit_byte = acc_q[ACC_W-1 -: BW] | (8'hFF >> cnt_q);
		emit_final = last_q && (cnt_q <= CNT_BYTE);
		acc_a = emit ? (acc_q << BW) : acc_q;
		cnt_a = emit ? ((cnt_q > CNT_BYTE) ? cnt_q - CNT_BYTE : '0) : cnt_q;
		last_a = last_q && !(emit && emit_final);
		pop = q_valid && (cnt_a < CNT_BYTE) && !last_a;
		acc_n = acc_a;
		cnt_n = cnt_a;
		last_n = last_a;
		if (pop) begin
			acc_n = acc_a | ({q_seg, {(BW-1){1'b0}}} >> cnt_a[2:0]);
			cnt_n = cnt_a + CNT_W'(q_len);
			last_n = q_last;
		end
	end

	// Hold accumulator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			cnt_q <= '0;
			last_q <= 1'b0;
		end else begin
			acc_q <= acc_n;
			cnt_q <= cnt_n;
			last_q <= last_n;
		end
	end

	// Output register: advance when empty or taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			byte_q <= emit_byte;
			final_q <= emit_final;
		end
	end

	assign packed_valid = out_valid_q;
	assign packed_byte = byte_q;
	assign final_byte = final_q;

endmodule

`default_nettype wire

// File: verif/tb_five_bit_text_packer_top.sv
// Self-checking testbench of the five-bit text packer: directed texts, random texts, stalls.
module tb_five_bit_text_packer_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_W = 10;
	localparam int HOLD_CYCLES = 90;
	localparam int QUIET_LIMIT = 2000;
	localparam int RANDOM_ITEMS = 195;
	localparam int DRAIN_CYCLES = 16;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} packed_rec_t;

	// Predicts the packed byte stream and checks the block's output against it
	class text_pack_checker;
		packed_rec_t expected_bytes[$];
		logic [6:0] held_bits;
		logic [2:0] held_cnt;
		logic [NUM_W-1:0] run_value;
		logic run_open;
		logic [31:0] acc;
		int unsigned acc_cnt;
		int errors;
		int chars_seen;
		int texts_seen;
		int bytes_checked;

		function new();
			held_bits = '0;
			held_cnt = '0;
			run_value = '0;
			run_open = 1'b0;
			errors = 0;
			chars_seen = 0;
			texts_seen = 0;
			bytes_checked = 0;
		endfunction

		// Queue one expected byte at the tail
		function void add_expected(input packed_rec_t rec);
			expected_bytes.insert(expected_bytes.size(), rec);
		endfunction

		// Map a character to its code; returns 0 for characters that carry none
		function bit char_code(input logic [7:0] ch,
			output logic [fbtp_pkg::CODE_W-1:0] code);
			code = fbtp_pkg::CODE_AT;
			if (ch >= fbtp_pkg::CHAR_A && ch <= fbtp_pkg::CHAR_Z) begin
				code = fbtp_pkg::CODE_W'(ch - fbtp_pkg::CHAR_A);
				return 1'b1;
			end
			case (ch)
				fbtp_pkg::CHAR_AT, fbtp_pkg::CHAR_NEWLINE: code = fbtp_pkg::CODE_AT;
				fbtp_pkg::CHAR_HASH: code = fbtp_pkg::CODE_HASH;
				fbtp_pkg::CHAR_COMMA: code = fbtp_pkg::CODE_COMMA;
				fbtp_pkg::CHAR_PERIOD: code = fbtp_pkg::CODE_PERIOD;
				fbtp_pkg::CHAR_SPACE: code = fbtp_pkg::CODE_SPACE;
				default: return 1'b0;
			endcase
			return 1'b1;
		endfunction

		// Append code bits and emit every complete byte
		function void append_bits(input logic [31:0] value, input int unsigned width);
			packed_rec_t rec;
			acc = (acc << width) | (value & ((32'd1 << width) - 1));
			acc_cnt += width;
			while (acc_cnt >= 8) begin
				rec.data = 8'(acc >> (acc_cnt - 8));
				rec.last = 1'b0;
				add_expected(rec);
				acc_cnt -= 8;
				acc &= (32'd1 << acc_cnt) - 1;
			end
		endfunction

		// Close an open digit run: escape code then the wrapped value
		function void close_run();
			if (run_open) begin
				append_bits(32'(fbtp_pkg::CODE_ESCAPE), fbtp_pkg::CODE_W);
				append_bits(32'(run_value), NUM_W);
			end
			run_open = 1'b0;
			run_value = '0;
		endfunction

		// Note one accepted character and queue the bytes it produces
		function void predict_char(input logic [7:0] ch, input logic eot);
			logic [fbtp_pkg::CODE_W-1:0] code;
			int unsigned pad;
			int first;
			packed_rec_t rec;
			chars_seen++;
			first = expected_bytes.size();
			acc = 32'(held_bits);
			acc_cnt = held_cnt;
			if (ch >= fbtp_pkg::CHAR_ZERO && ch <= fbtp_pkg::CHAR_NINE) begin
				run_value = NUM_W'(run_value * 10 + (ch - fbtp_pkg::CHAR_ZERO));
				run_open = 1'b1;
			end else begin
				bit hit;
				hit = char_code(ch, code);
				close_run();
				if (hit)
					append_bits(32'(code), fbtp_pkg::CODE_W);
			end
			if (eot) begin
				texts_seen++;
				close_run();
				if (ch != fbtp_pkg::CHAR_NEWLINE)
					append_bits(32'(fbtp_pkg::CODE_AT), fbtp_pkg::CODE_W);
				// pad the partial byte with ones
				if (acc_cnt > 0) begin
					pad = 8 - acc_cnt;
					rec.data = 8'((acc << pad) | ((32'd1 << pad) - 1));
					rec.last = 1'b0;
					add_expected(rec);
				end
				if (expected_bytes.size() > first) begin
					rec = expected_bytes.pop_back();
					rec.last = 1'b1;
					add_expected(rec);
				end
				held_bits = '0;
				held_cnt = '0;
			end else begin
				held_bits = acc[6:0];
				held_cnt = acc_cnt[2:0];
			end
		endfunction

		// Compare one output transaction with the oldest expected byte
		function void check_packed(input logic [7:0] data, input logic last);
			packed_rec_t exp_rec;
			bytes_checked++;
			if (expected_bytes.size() == 0) begin
				errors++;
				$display("%0t: unexpected packed byte %h final %b", $time, data, last);
				return;
			end
			exp_rec = expected_bytes.pop_front();
			if (data !== exp_rec.data) begin
				errors++;
				$display("%0t: packed_byte expected %h actual %h", $time, exp_rec.data, data);
			end
			if (last !== exp_rec.last) begin
				errors++;
				$display("%0t: final_byte expected %b actual %b", $time, exp_rec.last, last);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic text_valid = 1'b0;
	logic text_stall;
	logic [7:0] text_byte = 8'h00;
	logic end_of_text = 1'b0;
	logic packed_valid;
	logic packed_stall = 1'b0;
	logic [7:0] packed_byte;
	logic final_byte;

	text_pack_checker sb;
	bit calm = 1'b0;
	bit hold_req = 1'b0;
	int quiet_cycles = 0;

	five_bit_text_packer_top #(
		.NUMBER_WIDTH(NUM_W)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.text_valid(text_valid),
		.text_stall(text_stall),
		.text_byte(text_byte),
		.end_of_text(end_of_text),
		.packed_valid(packed_valid),
		.packed_stall(packed_stall),
		.packed_byte(packed_byte),
		.final_byte(final_byte)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Offer one character from a falling edge; return at the falling edge after acceptance
	task automatic send_char(input logic [7:0] ch, input logic eot);
		while (!calm && !hold_req && $urandom_range(0, 99) < 30) begin
			text_valid <= 1'b0;
			@(negedge clk);
		end
		text_valid <= 1'b1;
		text_byte <= ch;
		end_of_text <= eot;
		do
			@(posedge clk);
		while (text_stall);
		sb.predict_char(ch, eot);
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], i == s.len() - 1);
	endtask

	// Pick a character, mostly well-formed text with some noise
	function automatic logic [7:0] random_char();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return fbtp_pkg::CHAR_A + 8'($urandom_range(0, 25));
		if (r < 65)
			return fbtp_pkg::CHAR_ZERO + 8'($urandom_range(0, 9));
		if (r < 80) begin
			case ($urandom_range(0, 4))
				0: return fbtp_pkg::CHAR_SPACE;
				1: return fbtp_pkg::CHAR_COMMA;
				2: return fbtp_pkg::CHAR_PERIOD;
				3: return fbtp_pkg::CHAR_AT;
				default: return fbtp_pkg::CHAR_HASH;
			endcase
		end
		if (r < 88)
			return fbtp_pkg::CHAR_NEWLINE;
		return 8'($urandom_range(0, 255));
	endfunction

	initial begin : stimulus
		int len;
		int base;
		bit hold_done;
		sb = new();
		hold_done = 1'b0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		// Directed texts: symbols, run wrap, ends on letter, digit, newline, other
		send_text("z");
		send_text("a@#,. \n");
		send_text("99990");
		send_char(fbtp_pkg::CHAR_ZERO + 8'd7, 1'b0);
		send_char(8'hFF, 1'b0);
		send_char(fbtp_pkg::CHAR_ZERO + 8'd3, 1'b0);
		send_char(8'h00, 1'b1);
		send_text("5\nx");
		send_text("1x1");

		// Random texts with a calm stretch and one long output hold-off
		base = sb.chars_seen;
		while (sb.chars_seen - base < RANDOM_ITEMS) begin
			calm = (sb.chars_seen - base >= 100) && (sb.chars_seen - base < 160);
			if (!hold_done && sb.chars_seen - base >= 40) begin
				hold_req = 1'b1;
				hold_done = 1'b1;
			end
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12);
			for (int i = 0; i < len; i++)
				send_char(random_char(), i == len - 1);
		end
		calm = 1'b0;
		text_valid <= 1'b0;

		// Drain, then keep watching for stray bytes
		while (sb.expected_bytes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d characters in %0d texts, %0d packed bytes checked.",
			sb.chars_seen, sb.texts_seen, sb.bytes_checked);
		$display("Mismatches: %0d, bytes still expected: %0d.",
			sb.errors, sb.expected_bytes.size());
		if (sb.errors == 0 && sb.expected_bytes.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// Drive the output stall: random stalls, or one long hold-off on request
	initial begin : receiver
		int held;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				packed_stall <= 1'b1;
				for (held = 1; held < HOLD_CYCLES; held++)
					@(negedge clk);
				hold_req = 1'b0;
			end else if (!calm && $urandom_range(0, 99) < 30) begin
				packed_stall <= 1'b1;
			end else begin
				packed_stall <= 1'b0;
			end
		end
	end

	// Check each output transaction
	always @(posedge clk) begin
		if (arst_n && packed_valid && !packed_stall)
			sb.check_packed(packed_byte, final_byte);
	end

	// Stop the run if nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (text_valid && !text_stall) || (packed_valid && !packed_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

endmodule
